// ===== rtl/equal_power_stereo_panner_macros.svh =====
// Assertion helpers used by the checker in eps_check.sv.
`ifndef EQUAL_POWER_STEREO_PANNER_MACROS_SVH
`define EQUAL_POWER_STEREO_PANNER_MACROS_SVH

// same-cycle implication
`define EPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("panner check failed");

// next-cycle implication
`define EPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("panner check failed");

`endif

// ===== rtl/eps_pkg.sv =====
package eps_pkg;

  localparam int FRAME_COUNT = 512;

  localparam logic [15:0] HALF_POWER_GAIN = 16'd23170;
  localparam logic [15:0] GAIN_MAX = 16'd32767;

  localparam logic [3:0] REG_SOURCE_X      = 4'd0;
  localparam logic [3:0] REG_SOURCE_Y      = 4'd1;
  localparam logic [3:0] REG_SOURCE_Z      = 4'd2;
  localparam logic [3:0] REG_ROT_W         = 4'd3;
  localparam logic [3:0] REG_ROT_X         = 4'd4;
  localparam logic [3:0] REG_ROT_Y         = 4'd5;
  localparam logic [3:0] REG_ROT_Z         = 4'd6;
  localparam logic [3:0] REG_SPEAKER_COUNT = 4'd7;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } eps_cfg_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] gain_left;
    logic [15:0] gain_right;
  } eps_gain_t;

endpackage

// ===== rtl/equal_power_stereo_panner.sv =====
// Equal-power stereo panner.
//
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Indexes 0..7 select source_x/y/z, rot_w/x/y/z, speaker_count;
// other indexes are ignored. Write only while no sample is in flight.
// Each config transaction restarts the gain engine: it rotates the source by
// the quaternion, takes the azimuth and derives both Q1.15 gains with a shared
// square-root unit and a restoring divider, one bit per cycle. busy stays high
// for that run, whose length depends on the number of normalization shifts.
// The same run follows reset, so busy is high right after reset.
//
// Sample channel: a transaction is taken on a rising edge with start high and
// busy low. One sample per cycle is sustained while busy stays low, through a
// four-stage pipeline (input register, gain multiply, rounding, mix and
// saturate into the output register). Each result leaves the output register
// with done high for exactly one cycle; the receiver cannot stall, so there is
// no back-pressure path. Reset drops every transaction in flight.
module equal_power_stereo_panner (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] sample,
  input  logic signed [23:0] prior_left,
  input  logic signed [23:0] prior_right,
  input  logic [8:0]         frame_index,
  // result
  output logic               done,
  output logic signed [23:0] out_left,
  output logic signed [23:0] out_right,
  output logic [1:0]         write_mask,
  output logic [8:0]         frame_slot,
  // config channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  eps_pkg::eps_cfg_t  cfg;
  eps_pkg::eps_gain_t gain;
  logic [1:0]         speaker_count;
  logic               cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // config registers; reset gives the identity rotation and stereo output
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vx        <= '0;
      cfg.vy        <= '0;
      cfg.vz        <= '0;
      cfg.qw        <= 16'sd16384;
      cfg.qx        <= '0;
      cfg.qy        <= '0;
      cfg.qz        <= '0;
      speaker_count <= 2'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        eps_pkg::REG_SOURCE_X:      cfg.vx <= cfg_data;
        eps_pkg::REG_SOURCE_Y:      cfg.vy <= cfg_data;
        eps_pkg::REG_SOURCE_Z:      cfg.vz <= cfg_data;
        eps_pkg::REG_ROT_W:         cfg.qw <= cfg_data[15:0];
        eps_pkg::REG_ROT_X:         cfg.qx <= cfg_data[15:0];
        eps_pkg::REG_ROT_Y:         cfg.qy <= cfg_data[15:0];
        eps_pkg::REG_ROT_Z:         cfg.qz <= cfg_data[15:0];
        eps_pkg::REG_SPEAKER_COUNT: speaker_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // gains only change on config, so they are computed once per write
  eps_gain u_gain (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_write),
    .cfg     (cfg),
    .gain    (gain)
  );

  assign busy = gain.busy;

  logic accept;
  assign accept = start && !busy;

  // stage 1: capture the transaction
  logic               v1;
  logic signed [23:0] s1, pl1, pr1;
  logic [8:0]         idx1;

  // stage 2: gain times sample
  logic               v2;
  logic signed [40:0] ml2, mr2;
  logic signed [23:0] s2, pl2, pr2;
  logic [8:0]         idx2;

  // stage 3: rounded Q1.23 contributions
  logic               v3;
  logic signed [25:0] rl3, rr3;
  logic signed [23:0] s3, pl3, pr3;
  logic [8:0]         idx3;

  logic signed [16:0] gl_s, gr_s;
  assign gl_s = $signed({1'b0, gain.gain_left});
  assign gr_s = $signed({1'b0, gain.gain_right});

  localparam logic signed [40:0] ROUND_HALF = 41'sd16384;

  function automatic logic signed [23:0] sat24(input logic signed [23:0] p,
                                               input logic signed [25:0] d);
    logic signed [26:0] t;
    t = 27'(p) + 27'(d);
    if (t > 27'sd8388607) sat24 = 24'sh7FFFFF;
    else if (t < -27'sd8388608) sat24 = 24'sh800000;
    else sat24 = 24'(t);
  endfunction

  logic in_frame;
  assign in_frame = {1'b0, idx3} < 10'(eps_pkg::FRAME_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s1   <= sample;
    pl1  <= prior_left;
    pr1  <= prior_right;
    idx1 <= frame_index;

    ml2  <= gl_s * s1;
    mr2  <= gr_s * s1;
    s2   <= s1;
    pl2  <= pl1;
    pr2  <= pr1;
    idx2 <= idx1;

    rl3  <= 26'((ml2 + ROUND_HALF) >>> 15);
    rr3  <= 26'((mr2 + ROUND_HALF) >>> 15);
    s3   <= s2;
    pl3  <= pl2;
    pr3  <= pr2;
    idx3 <= idx2;

    frame_slot <= idx3;
    if (!in_frame || speaker_count == 2'd0) begin
      out_left   <= '0;
      out_right  <= '0;
      write_mask <= 2'b00;
    end else if (speaker_count == 2'd1) begin
      // mono: channel 0 takes the dry sample
      out_left   <= s3;
      out_right  <= '0;
      write_mask <= 2'b01;
    end else begin
      out_left   <= sat24(pl3, rl3);
      out_right  <= sat24(pr3, rr3);
      write_mask <= 2'b11;
    end
  end

endmodule

// ===== rtl/eps_gain.sv =====
module eps_gain (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  eps_pkg::eps_cfg_t cfg,
  output eps_pkg::eps_gain_t gain
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PROD = 4'd1;
  localparam logic [3:0] ST_MAT  = 4'd2;
  localparam logic [3:0] ST_DOT  = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_NORM = 4'd5;
  localparam logic [3:0] ST_SQ   = 4'd6;
  localparam logic [3:0] ST_ROOT = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_GSQ  = 4'd9;

  logic [3:0] state;
  logic [4:0] cnt;
  logic       side;

  logic signed [31:0] prod [10];
  logic signed [33:0] ext [10];
  logic signed [25:0] m [6];
  logic signed [57:0] rx, rz;
  logic [56:0] ax, az;
  logic        neg;
  logic [61:0] sum_sq;
  logic [30:0] r;
  logic [62:0] sq_n, sq_root, sq_bit;
  logic [30:0] rem, low, quo;
  logic [15:0] gain_left, gain_right;

  // quaternion products: ww xx yy zz xy wz xz wy yz wx
  logic signed [15:0] pa, pb;
  logic signed [31:0] prod_val;

  always_comb begin
    case (cnt[3:0])
      4'd0: begin pa = cfg.qw; pb = cfg.qw; end
      4'd1: begin pa = cfg.qx; pb = cfg.qx; end
      4'd2: begin pa = cfg.qy; pb = cfg.qy; end
      4'd3: begin pa = cfg.qz; pb = cfg.qz; end
      4'd4: begin pa = cfg.qx; pb = cfg.qy; end
      4'd5: begin pa = cfg.qw; pb = cfg.qz; end
      4'd6: begin pa = cfg.qx; pb = cfg.qz; end
      4'd7: begin pa = cfg.qw; pb = cfg.qy; end
      4'd8: begin pa = cfg.qy; pb = cfg.qz; end
      4'd9: begin pa = cfg.qw; pb = cfg.qx; end
      default: begin pa = cfg.qw; pb = cfg.qw; end
    endcase
  end

  assign prod_val = pa * pb;

  for (genvar i = 0; i < 10; i++) begin : g_ext
    assign ext[i] = 34'(prod[i]);
  end

  // matrix rows for X and Z, floored to Q6.20
  logic signed [25:0] m_n [6];
  assign m_n[0] = 26'((ext[0] + ext[1] - ext[2] - ext[3]) >>> 8);
  assign m_n[1] = 26'((ext[4] - ext[5]) >>> 7);
  assign m_n[2] = 26'((ext[6] + ext[7]) >>> 7);
  assign m_n[3] = 26'((ext[6] - ext[7]) >>> 7);
  assign m_n[4] = 26'((ext[8] + ext[9]) >>> 7);
  assign m_n[5] = 26'((ext[0] - ext[1] - ext[2] + ext[3]) >>> 8);

  logic signed [25:0] dot_a;
  logic signed [31:0] dot_b;
  logic signed [57:0] dot_p;

  always_comb begin
    case (cnt[2:0])
      3'd0: begin dot_a = m[0]; dot_b = cfg.vx; end
      3'd1: begin dot_a = m[1]; dot_b = cfg.vy; end
      3'd2: begin dot_a = m[2]; dot_b = cfg.vz; end
      3'd3: begin dot_a = m[3]; dot_b = cfg.vx; end
      3'd4: begin dot_a = m[4]; dot_b = cfg.vy; end
      3'd5: begin dot_a = m[5]; dot_b = cfg.vz; end
      default: begin dot_a = m[0]; dot_b = cfg.vx; end
    endcase
  end

  assign dot_p = dot_a * dot_b;

  logic [29:0] sq_a;
  logic [59:0] sq_p;
  assign sq_a = cnt[0] ? az[29:0] : ax[29:0];
  assign sq_p = sq_a * sq_a;

  // one step of the digit-by-digit square root
  logic [62:0] sq_t, sq_n_next, sq_root_next;
  logic        sq_ge;
  assign sq_t = sq_root + sq_bit;
  assign sq_ge = sq_n >= sq_t;
  assign sq_n_next = sq_ge ? sq_n - sq_t : sq_n;
  assign sq_root_next = sq_ge ? (sq_root >> 1) + sq_bit : sq_root >> 1;

  // one step of restoring division by r
  logic [31:0] div_t;
  logic        div_ge;
  logic [31:0] div_t_sub;
  assign div_t = {rem, low[30]};
  assign div_ge = div_t >= {1'b0, r};
  assign div_t_sub = div_t - {1'b0, r};

  // r - X for the left channel, r + X for the right one
  function automatic logic [32:0] pan_num(input logic [30:0] rr, input logic [29:0] a,
                                          input logic add);
    pan_num = add ? 33'(rr) + 33'(a) : 33'(rr) - 33'(a);
  endfunction

  logic [32:0] num_left, num_right;
  assign num_left  = pan_num(31'(sq_root_next), ax[29:0], neg);
  assign num_right = pan_num(r, ax[29:0], !neg);

  logic [15:0] gain_clamped;
  assign gain_clamped = (sq_root_next > 63'(eps_pkg::GAIN_MAX)) ?
                        eps_pkg::GAIN_MAX : 16'(sq_root_next);

  localparam logic [62:0] SQ_BIT_TOP = 63'd1 << 62;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= ST_PROD;
      cnt   <= '0;
    end else begin
      case (state)
        ST_PROD: begin
          prod[cnt[3:0]] <= prod_val;
          if (cnt == 5'd9) begin
            state <= ST_MAT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_MAT: begin
          for (int i = 0; i < 6; i++) m[i] <= m_n[i];
          rx    <= '0;
          rz    <= '0;
          state <= ST_DOT;
        end
        ST_DOT: begin
          if (cnt < 5'd3) rx <= rx + dot_p;
          else rz <= rz + dot_p;
          if (cnt == 5'd5) begin
            state <= ST_CHK;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_CHK: begin
          if (rx == '0 && rz == '0) begin
            gain_left  <= eps_pkg::HALF_POWER_GAIN;
            gain_right <= eps_pkg::HALF_POWER_GAIN;
            state      <= ST_IDLE;
          end else begin
            neg   <= rx[57];
            ax    <= 57'(rx[57] ? -rx : rx);
            az    <= 57'(rz[57] ? -rz : rz);
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if ((ax[56:30] | az[56:30]) != '0) begin
            ax <= ax >> 1;
            az <= az >> 1;
          end else begin
            state <= ST_SQ;
            cnt   <= '0;
          end
        end
        ST_SQ: begin
          if (cnt == 5'd0) begin
            sum_sq <= 62'(sq_p);
            cnt    <= 5'd1;
          end else begin
            sq_n    <= 63'(sum_sq) + 63'(sq_p);
            sq_root <= '0;
            sq_bit  <= SQ_BIT_TOP;
            cnt     <= '0;
            state   <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          sq_n    <= sq_n_next;
          sq_root <= sq_root_next;
          sq_bit  <= sq_bit >> 2;
          cnt     <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            r     <= 31'(sq_root_next);
            rem   <= num_left[32:2];
            low   <= {num_left[1:0], 29'd0};
            quo   <= '0;
            side  <= 1'b0;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= div_ge ? 31'(div_t_sub) : 31'(div_t);
          low <= low << 1;
          quo <= {quo[29:0], div_ge};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            sq_n    <= 63'({quo[29:0], div_ge});
            sq_root <= '0;
            sq_bit  <= SQ_BIT_TOP;
            cnt     <= '0;
            state   <= ST_GSQ;
          end
        end
        ST_GSQ: begin
          sq_n    <= sq_n_next;
          sq_root <= sq_root_next;
          sq_bit  <= sq_bit >> 2;
          cnt     <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            if (!side) begin
              gain_left <= gain_clamped;
              rem       <= num_right[32:2];
              low       <= {num_right[1:0], 29'd0};
              quo       <= '0;
              side      <= 1'b1;
              cnt       <= '0;
              state     <= ST_DIV;
            end else begin
              gain_right <= gain_clamped;
              state      <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign gain.busy       = (state != ST_IDLE);
  assign gain.gain_left  = gain_left;
  assign gain.gain_right = gain_right;

endmodule

// ===== rtl/eps_check.sv =====
`include "equal_power_stereo_panner_macros.svh"

module eps_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [8:0] frame_index,
  input logic [8:0] frame_slot,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  `EPS_ASSERT_IMPL(a_latency, clk, rst, start && !busy, ##4 done)
  `EPS_ASSERT_IMPL(a_no_orphan, clk, rst, done, $past(start && !busy, 4))
  `EPS_ASSERT_IMPL(a_slot_echo, clk, rst, done, frame_slot == $past(frame_index, 4))
  `EPS_ASSERT_NEXT(a_cfg_busy, clk, rst, cfg_valid && cfg_ready, busy)

endmodule

bind equal_power_stereo_panner eps_check u_eps_check (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .frame_index (frame_index),
  .frame_slot  (frame_slot),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready)
);
